// ----- rtl/dmc_pkg.sv -----
// ============================================================================
// dmc_pkg
// Shared types and constants of the depth-first maze carver.
// ============================================================================
`default_nettype none

package dmc_pkg;

	// Grid limits in squares, outer walls included
	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int HALF_ROWS  = MAX_ROWS / 2;
	localparam int HALF_COLS  = MAX_COLS / 2;
	localparam int CELL_COUNT = HALF_ROWS * HALF_COLS;

	// Cell index is {half row, half column}
	localparam int HR_W   = $clog2(HALF_ROWS);
	localparam int HC_W   = $clog2(HALF_COLS);
	localparam int CELL_W = HR_W + HC_W;
	localparam int CNT_W  = $clog2(CELL_COUNT + 1);

	// Fixed field widths of the channels
	localparam int GRID_W    = 7;
	localparam int RAND_W    = 8;
	localparam int COORD_W   = 6;
	localparam int DEPTH_W   = 11;
	localparam int CFG_IDX_W = 2;

	// Width for bound compares on grid dimensions
	localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int CMP_W   = $clog2(MAX_DIM + (2 ** GRID_W)) + 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

	// Request codes
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	typedef enum logic [1:0] {
		EV_STARTED     = 2'd0,
		EV_CARVED      = 2'd1,
		EV_BACKTRACKED = 2'd2,
		EV_FINISHED    = 2'd3
	} ev_t;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_TOP,
		ST_MID,
		ST_UP,
		ST_DOWN,
		ST_DONE
	} state_t;

	// Clamped grid dimensions
	typedef struct packed {
		logic [CMP_W-1:0] w_lim;
		logic [CMP_W-1:0] h_lim;
	} grid_cfg_t;

	typedef struct packed {
		ev_t                event_res;
		logic [COORD_W-1:0] cell_row;
		logic [COORD_W-1:0] cell_col;
		logic [COORD_W-1:0] link_row;
		logic [COORD_W-1:0] link_col;
		logic [DEPTH_W-1:0] stack_depth;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/dmc_if.sv -----
// ============================================================================
// dmc_if
// Valid/ready channels of the maze carver: request, result, configuration.
// ============================================================================
`default_nettype none

interface dmc_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [dmc_pkg::RAND_W-1:0]  rand_value;

	modport source (output valid, req_type, rand_value, input ready);
	modport sink   (input valid, req_type, rand_value, output ready);
endinterface

interface dmc_res_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  event_res;
	logic [dmc_pkg::COORD_W-1:0] cell_row;
	logic [dmc_pkg::COORD_W-1:0] cell_col;
	logic [dmc_pkg::COORD_W-1:0] link_row;
	logic [dmc_pkg::COORD_W-1:0] link_col;
	logic [dmc_pkg::DEPTH_W-1:0] stack_depth;

	modport source (output valid, event_res, cell_row, cell_col, link_row, link_col,
		stack_depth, input ready);
	modport sink   (input valid, event_res, cell_row, cell_col, link_row, link_col,
		stack_depth, output ready);
endinterface

interface dmc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [dmc_pkg::CFG_IDX_W-1:0] index;
	logic [dmc_pkg::GRID_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dmc_ram.sv -----
// ============================================================================
// dmc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module dmc_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/dmc_ctrl.sv -----
// ============================================================================
// dmc_ctrl
// Carver sequencer: reads stack top and three visited rows, picks a
// neighbour, writes the visited row back and pushes or pops the stack.
// ============================================================================
`default_nettype none

module dmc_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire dmc_pkg::grid_cfg_t               grid,
	// request transaction
	input  wire logic                             req_valid,
	output logic                                  req_ready,
	input  wire logic                             req_type,
	input  wire logic [dmc_pkg::RAND_W-1:0]       rand_value,
	// result transaction
	output logic                                  res_valid,
	input  wire logic                             res_ready,
	output dmc_pkg::result_t                      res,
	// visited map, one row of cells per entry
	output logic                                  vis_we,
	output logic      [dmc_pkg::HR_W-1:0]         vis_waddr,
	output logic      [dmc_pkg::HALF_COLS-1:0]    vis_wdata,
	output logic      [dmc_pkg::HR_W-1:0]         vis_raddr,
	input  wire logic [dmc_pkg::HALF_COLS-1:0]    vis_rdata,
	// path stack
	output logic                                  stk_we,
	output logic      [dmc_pkg::CELL_W-1:0]       stk_waddr,
	output logic      [dmc_pkg::CELL_W-1:0]       stk_wdata,
	output logic      [dmc_pkg::CELL_W-1:0]       stk_raddr,
	input  wire logic [dmc_pkg::CELL_W-1:0]       stk_rdata
);

	localparam int CMP_W = dmc_pkg::CMP_W;
	localparam int HR_W  = dmc_pkg::HR_W;
	localparam int HC_W  = dmc_pkg::HC_W;
	localparam int CW    = dmc_pkg::COORD_W;

	dmc_pkg::state_t state_q, state_nxt;

	logic [dmc_pkg::CNT_W-1:0]     count_q;
	logic [dmc_pkg::CNT_W-1:0]     cnt_m1;
	logic [HR_W-1:0]               clr_q;
	logic [dmc_pkg::RAND_W-1:0]    rand_q;
	logic [dmc_pkg::CELL_W-1:0]    top_q;
	logic [dmc_pkg::HALF_COLS-1:0] mid_q;
	logic [dmc_pkg::HALF_COLS-1:0] up_q;
	dmc_pkg::result_t              res_q;

	logic                          accept;
	logic [HR_W-1:0]               hr, hr_m1, hr_p1, new_hr;
	logic [HC_W-1:0]               hc, hc_m1, hc_p1, new_hc;
	logic [3:0]                    cand;
	logic [2:0]                    n_cand;
	logic [10:0]                   prod;
	logic [1:0]                    pick;
	dmc_pkg::dir_t                 sel;
	logic [CW-1:0]                 link_r, link_c;
	logic [dmc_pkg::HALF_COLS-1:0] wr_row;
	logic                          can_push;

	// Cell at (2x+1) lies inside a dimension lim when 2x+3 <= lim
	function automatic logic fits(input logic [CMP_W-1:0] x, input logic [CMP_W-1:0] lim);
		fits = ({x[CMP_W-2:0], 1'b0} + CMP_W'(3)) <= lim;
	endfunction

	assign accept   = req_valid && req_ready;
	assign cnt_m1   = count_q - dmc_pkg::CNT_W'(1);
	assign can_push = count_q < dmc_pkg::CNT_W'(dmc_pkg::CELL_COUNT);

	assign hr    = top_q[dmc_pkg::CELL_W-1:HC_W];
	assign hc    = top_q[HC_W-1:0];
	assign hr_m1 = hr - HR_W'(1);
	assign hr_p1 = hr + HR_W'(1);
	assign hc_m1 = hc - HC_W'(1);
	assign hc_p1 = hc + HC_W'(1);

	// Neighbour evaluation, valid in ST_DOWN when the down row is on vis_rdata
	always_comb begin
		logic [1:0] seen;
		logic       found;
		cand[dmc_pkg::DIR_UP]    = (hr != '0) && fits(CMP_W'(hr) - CMP_W'(1), grid.h_lim)
			&& fits(CMP_W'(hc), grid.w_lim) && !up_q[hc];
		cand[dmc_pkg::DIR_DOWN]  = fits(CMP_W'(hr) + CMP_W'(1), grid.h_lim)
			&& fits(CMP_W'(hc), grid.w_lim) && !vis_rdata[hc];
		cand[dmc_pkg::DIR_LEFT]  = (hc != '0) && fits(CMP_W'(hr), grid.h_lim)
			&& fits(CMP_W'(hc) - CMP_W'(1), grid.w_lim) && !mid_q[hc_m1];
		cand[dmc_pkg::DIR_RIGHT] = fits(CMP_W'(hr), grid.h_lim)
			&& fits(CMP_W'(hc) + CMP_W'(1), grid.w_lim) && !mid_q[hc_p1];

		n_cand = {2'b00, cand[0]} + {2'b00, cand[1]} + {2'b00, cand[2]} + {2'b00, cand[3]};
		prod   = 11'(rand_q) * 11'(n_cand);
		pick   = prod[9:8];

		// pick-th candidate in up, down, left, right order
		sel   = dmc_pkg::DIR_UP;
		seen  = 2'd0;
		found = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (cand[i] && !found) begin
				if (seen == pick) begin
					sel   = dmc_pkg::dir_t'(2'(i));
					found = 1'b1;
				end
				seen = seen + 2'd1;
			end
		end

		new_hr = hr;
		new_hc = hc;
		link_r = CW'({hr, 1'b1});
		link_c = CW'({hc, 1'b1});
		wr_row = mid_q;
		case (sel)
			dmc_pkg::DIR_UP: begin
				new_hr = hr_m1;
				link_r = CW'({hr, 1'b0});
				wr_row = up_q;
			end
			dmc_pkg::DIR_DOWN: begin
				new_hr = hr_p1;
				link_r = CW'({hr, 1'b0}) + CW'(2);
				wr_row = vis_rdata;
			end
			dmc_pkg::DIR_LEFT: begin
				new_hc = hc_m1;
				link_c = CW'({hc, 1'b0});
			end
			dmc_pkg::DIR_RIGHT: begin
				new_hc = hc_p1;
				link_c = CW'({hc, 1'b0}) + CW'(2);
			end
			default: ;
		endcase
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dmc_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_type == dmc_pkg::REQ_START) begin
						state_nxt = dmc_pkg::ST_CLEAR;
					end else if (count_q == '0) begin
						state_nxt = dmc_pkg::ST_DONE;
					end else begin
						state_nxt = dmc_pkg::ST_TOP;
					end
				end
			end
			dmc_pkg::ST_CLEAR: begin
				if (clr_q == HR_W'(dmc_pkg::HALF_ROWS - 1)) begin
					state_nxt = dmc_pkg::ST_DONE;
				end
			end
			dmc_pkg::ST_TOP:  state_nxt = dmc_pkg::ST_MID;
			dmc_pkg::ST_MID:  state_nxt = dmc_pkg::ST_UP;
			dmc_pkg::ST_UP:   state_nxt = dmc_pkg::ST_DOWN;
			dmc_pkg::ST_DOWN: state_nxt = dmc_pkg::ST_DONE;
			dmc_pkg::ST_DONE: begin
				if (res_ready) begin
					state_nxt = dmc_pkg::ST_IDLE;
				end
			end
			default: state_nxt = dmc_pkg::ST_IDLE;
		endcase
	end

	// Handshakes and memory controls
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		vis_we    = 1'b0;
		vis_waddr = new_hr;
		vis_wdata = wr_row;
		vis_wdata[new_hc] = 1'b1;
		vis_raddr = hr;
		stk_we    = 1'b0;
		stk_waddr = count_q[dmc_pkg::CELL_W-1:0];
		stk_wdata = {new_hr, new_hc};
		stk_raddr = cnt_m1[dmc_pkg::CELL_W-1:0];
		unique case (state_q)
			dmc_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				// start cell goes to the stack bottom
				if (accept && req_type == dmc_pkg::REQ_START) begin
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = '0;
				end
			end
			dmc_pkg::ST_CLEAR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_q;
				vis_wdata = (clr_q == '0) ? dmc_pkg::HALF_COLS'(1) : '0;
			end
			dmc_pkg::ST_TOP: vis_raddr = stk_rdata[dmc_pkg::CELL_W-1:HC_W];
			dmc_pkg::ST_MID: vis_raddr = hr_m1;
			dmc_pkg::ST_UP:  vis_raddr = hr_p1;
			dmc_pkg::ST_DOWN: begin
				if (n_cand != '0) begin
					vis_we = 1'b1;
					stk_we = can_push;
				end
			end
			dmc_pkg::ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmc_pkg::ST_IDLE;
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == dmc_pkg::ST_IDLE && accept && req_type == dmc_pkg::REQ_START) begin
				count_q <= dmc_pkg::CNT_W'(1);
				clr_q   <= '0;
			end
			if (state_q == dmc_pkg::ST_CLEAR) begin
				clr_q <= clr_q + HR_W'(1);
			end
			if (state_q == dmc_pkg::ST_DOWN) begin
				if (n_cand == '0) begin
					count_q <= cnt_m1;
				end else if (can_push) begin
					count_q <= count_q + dmc_pkg::CNT_W'(1);
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			dmc_pkg::ST_IDLE: begin
				if (accept) begin
					rand_q <= rand_value;
					if (req_type == dmc_pkg::REQ_START) begin
						res_q <= '{event_res: dmc_pkg::EV_STARTED, cell_row: CW'(1),
							cell_col: CW'(1), link_row: '0, link_col: '0,
							stack_depth: dmc_pkg::DEPTH_W'(1)};
					end else begin
						res_q <= '{event_res: dmc_pkg::EV_FINISHED, cell_row: '0,
							cell_col: '0, link_row: '0, link_col: '0,
							stack_depth: '0};
					end
				end
			end
			dmc_pkg::ST_TOP: top_q <= stk_rdata;
			dmc_pkg::ST_MID: mid_q <= vis_rdata;
			dmc_pkg::ST_UP:  up_q  <= vis_rdata;
			dmc_pkg::ST_DOWN: begin
				if (n_cand == '0) begin
					res_q.event_res   <= dmc_pkg::EV_BACKTRACKED;
					res_q.cell_row    <= CW'({hr, 1'b1});
					res_q.cell_col    <= CW'({hc, 1'b1});
					res_q.link_row    <= '0;
					res_q.link_col    <= '0;
					res_q.stack_depth <= dmc_pkg::DEPTH_W'(cnt_m1);
				end else begin
					res_q.event_res   <= dmc_pkg::EV_CARVED;
					res_q.cell_row    <= CW'({new_hr, 1'b1});
					res_q.cell_col    <= CW'({new_hc, 1'b1});
					res_q.link_row    <= link_r;
					res_q.link_col    <= link_c;
					res_q.stack_depth <= can_push
						? dmc_pkg::DEPTH_W'(count_q + dmc_pkg::CNT_W'(1))
						: dmc_pkg::DEPTH_W'(count_q);
				end
			end
			default: ;
		endcase
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ----- rtl/dfs_maze_carver.sv -----
// Step request: the sequencer passes ST_TOP, ST_MID, ST_UP, ST_DOWN and ST_DONE,
//   stalling in ST_DONE until the output register takes the result; the stack read
//   and three row reads through the single read port of the visited map set these states.
// Start request: ST_CLEAR makes a pass over all 32 visited-map rows to clear the map.
// A step on an empty stack (finished) goes straight to ST_DONE.
// Reset clears the control state and the stack count and sets width 49, height 21.
// ============================================================================
// dfs_maze_carver
// Randomised depth-first maze carver with an explicit stack of cells.
// ============================================================================
`default_nettype none

module dfs_maze_carver (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dmc_req_if.sink    req,
	dmc_res_if.source  res,
	dmc_cfg_if.sink    cfg
);

	localparam int CMP_W = dmc_pkg::CMP_W;

	logic [dmc_pkg::GRID_W-1:0]    grid_width_q;
	logic [dmc_pkg::GRID_W-1:0]    grid_height_q;
	dmc_pkg::grid_cfg_t            grid;

	logic                          res_valid;
	logic                          res_ready;
	dmc_pkg::result_t              res_data;
	logic                          out_valid_q;
	dmc_pkg::result_t              out_q;

	logic                          vis_we;
	logic [dmc_pkg::HR_W-1:0]      vis_waddr;
	logic [dmc_pkg::HALF_COLS-1:0] vis_wdata;
	logic [dmc_pkg::HR_W-1:0]      vis_raddr;
	logic [dmc_pkg::HALF_COLS-1:0] vis_rdata;
	logic                          stk_we;
	logic [dmc_pkg::CELL_W-1:0]    stk_waddr;
	logic [dmc_pkg::CELL_W-1:0]    stk_wdata;
	logic [dmc_pkg::CELL_W-1:0]    stk_raddr;
	logic [dmc_pkg::CELL_W-1:0]    stk_rdata;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= dmc_pkg::GRID_W'(49);
			grid_height_q <= dmc_pkg::GRID_W'(21);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				dmc_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg.data;
				dmc_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Clamp to the map size
	assign grid.w_lim = (CMP_W'(grid_width_q) > CMP_W'(dmc_pkg::MAX_COLS))
		? CMP_W'(dmc_pkg::MAX_COLS) : CMP_W'(grid_width_q);
	assign grid.h_lim = (CMP_W'(grid_height_q) > CMP_W'(dmc_pkg::MAX_ROWS))
		? CMP_W'(dmc_pkg::MAX_ROWS) : CMP_W'(grid_height_q);

	// Sequencer
	dmc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.grid       (grid),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_type   (req.req_type),
		.rand_value (req.rand_value),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res_data),
		.vis_we     (vis_we),
		.vis_waddr  (vis_waddr),
		.vis_wdata  (vis_wdata),
		.vis_raddr  (vis_raddr),
		.vis_rdata  (vis_rdata),
		.stk_we     (stk_we),
		.stk_waddr  (stk_waddr),
		.stk_wdata  (stk_wdata),
		.stk_raddr  (stk_raddr),
		.stk_rdata  (stk_rdata)
	);

	// Visited map, one row of cells per word
	dmc_ram #(
		.DEPTH (dmc_pkg::HALF_ROWS),
		.WIDTH (dmc_pkg::HALF_COLS)
	) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

	// Path stack
	dmc_ram #(
		.DEPTH (dmc_pkg::CELL_COUNT),
		.WIDTH (dmc_pkg::CELL_W)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Output register
	assign res_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res_data;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.event_res   = out_q.event_res;
	assign res.cell_row    = out_q.cell_row;
	assign res.cell_col    = out_q.cell_col;
	assign res.link_row    = out_q.link_row;
	assign res.link_col    = out_q.link_col;
	assign res.stack_depth = out_q.stack_depth;

endmodule

`default_nettype wire
